[design/arcade_video_timing_io_decoder_assert.svh]
// Assertion macros for the video timing / I/O decoder.
// AVTIO_ASSERT checks a property while out of reset.
// AVTIO_ASSERT_ALWAYS checks a property at every edge, reset included.
`ifndef ARCADE_VIDEO_TIMING_IO_DECODER_ASSERT_SVH
`define ARCADE_VIDEO_TIMING_IO_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define AVTIO_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("avtio: check failed");

`define AVTIO_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("avtio: invariant failed");

`else

`define AVTIO_ASSERT(lbl, clk, rst_n, prop)

`define AVTIO_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[design/avtio_pkg.sv]
package avtio_pkg;

    // Video timing
    localparam int LINE_TICKS   = 170;
    localparam int FRAME_LINES  = 320;
    localparam int VSYNC_PERIOD = 50000;
    localparam int VBLANK_TICKS = 3990;

    localparam int HCOUNT_W = $clog2(LINE_TICKS);
    localparam int VCOUNT_W = $clog2(FRAME_LINES);
    localparam int VSYNC_W  = $clog2(VSYNC_PERIOD);
    localparam int VBLANK_W = $clog2(VBLANK_TICKS + 1);

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int SCANLINE_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Bus request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_SWITCH_0 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_SWITCH_1 = 1'd1;

    // Board I/O map
    localparam logic [ADDR_W-1:0] ADDR_SCANLINE = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_DSW1     = 16'hC200;
    localparam logic [ADDR_W-1:0] ADDR_IN0      = 16'hC300;
    localparam logic [ADDR_W-1:0] ADDR_IN1      = 16'hC320;
    localparam logic [ADDR_W-1:0] ADDR_IN2      = 16'hC340;
    localparam logic [ADDR_W-1:0] ADDR_DSW0     = 16'hC360;
    localparam logic [ADDR_W-1:0] ADDR_NMI_EN   = 16'hC300;
    localparam logic [ADDR_W-1:0] ADDR_LATCH_2  = 16'hC302;
    localparam logic [ADDR_W-1:0] ADDR_LATCH_4  = 16'hC304;
    localparam logic [ADDR_W-1:0] ADDR_LATCH_8  = 16'hC308;
    localparam logic [ADDR_W-1:0] ADDR_LATCH_A  = 16'hC30A;
    localparam logic [ADDR_W-1:0] ADDR_LATCH_C  = 16'hC30C;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] bus_addr;
        logic [DATA_W-1:0] bus_wdata;
        logic [DATA_W-1:0] port_in0;
        logic [DATA_W-1:0] port_in1;
        logic [DATA_W-1:0] port_in2;
    } cmd_t;

    typedef struct packed {
        logic                  nmi_level;
        logic                  io_read_hit;
        logic [DATA_W-1:0]     io_read_data;
        logic                  mem_read;
        logic                  mem_write;
        logic [ADDR_W-1:0]     mem_addr;
        logic [DATA_W-1:0]     mem_wdata;
        logic [SCANLINE_W-1:0] scanline;
    } rsp_t;

endpackage

[design/avtio_cmd_if.sv]
interface avtio_cmd_if;
    logic              valid;
    logic              ready;
    avtio_pkg::cmd_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/avtio_rsp_if.sv]
interface avtio_rsp_if;
    logic              valid;
    logic              ready;
    avtio_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/arcade_video_timing_io_decoder.sv]
// Board glue of a Z80 arcade machine: video timing, NMI and I/O decode.
// cmd: one request per CPU tick (bus access code, address, write data and
//   the three player input ports). Every accepted request advances the
//   horizontal / scanline counters and the vsync / vblank countdowns.
// rsp: one result per request: NMI level, decoded read data or the access
//   forwarded to memory, and the scanline after this tick.
// cfg: plain write port for the two DIP switch banks (index 0 and 1).
// Result: registered, and valid the cycle after the request is taken.
// Throughput: one request per cycle unless rsp stalls; the timing update
//   and decode are a single pass of logic between the state and result registers.
// Stall: the result register holds while rsp.ready is low; cmd.ready is
//   high whenever that register is empty or being drained this cycle, so a
//   waiting request is held back only while the receiver stalls a full
//   result register, and nothing is lost.
// Reset: counters, countdowns and the NMI enable clear to zero, DIP banks
//   read as zero, and the result register is empty. The first accepted
//   request finds vsync at zero and so starts a vblank at once.
// Configuration writes take effect on the next request.
`include "arcade_video_timing_io_decoder_assert.svh"

module arcade_video_timing_io_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    avtio_cmd_if.sink                           cmd,
    avtio_rsp_if.source                         rsp,
    input  logic                                cfg_we,
    input  logic [avtio_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avtio_pkg::DATA_W-1:0]        cfg_wdata
);

    localparam logic [avtio_pkg::HCOUNT_W-1:0] HCOUNT_LAST =
        avtio_pkg::HCOUNT_W'(avtio_pkg::LINE_TICKS - 1);
    localparam logic [avtio_pkg::VCOUNT_W-1:0] VCOUNT_LAST =
        avtio_pkg::VCOUNT_W'(avtio_pkg::FRAME_LINES - 1);
    localparam logic [avtio_pkg::VSYNC_W-1:0] VSYNC_RELOAD =
        avtio_pkg::VSYNC_W'(avtio_pkg::VSYNC_PERIOD - 1);
    localparam logic [avtio_pkg::VBLANK_W-1:0] VBLANK_LOAD =
        avtio_pkg::VBLANK_W'(avtio_pkg::VBLANK_TICKS);

    // Timing state
    logic [avtio_pkg::HCOUNT_W-1:0] hcount_reg, hcount_next;
    logic [avtio_pkg::VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [avtio_pkg::VSYNC_W-1:0]  vsync_reg,  vsync_next;
    logic [avtio_pkg::VBLANK_W-1:0] vblank_reg, vblank_next;
    logic                           nmi_en_reg, nmi_en_next;

    // DIP switch banks
    logic [avtio_pkg::DATA_W-1:0] dip0_reg;
    logic [avtio_pkg::DATA_W-1:0] dip1_reg;

    // Result register
    logic             rsp_valid_reg;
    avtio_pkg::rsp_t  rsp_data_reg, rsp_data_next;

    logic cmd_take;
    logic vblank_src_nz;
    logic [avtio_pkg::VCOUNT_W-1:0] vcount_adv;
    logic [avtio_pkg::SCANLINE_W-1:0] scan_next;
    logic [2:0] rsp_targets;

    // Take a new request when the result slot is free or draining now.
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_take  = cmd.valid && cmd.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Video timing: advance horizontal, then the frame countdowns.
    always_comb
    begin
        hcount_next = hcount_reg + 1'b1;
        vcount_adv  = vcount_reg;
        if (hcount_reg == HCOUNT_LAST)
        begin
            hcount_next = '0;
            vcount_adv  = (vcount_reg == VCOUNT_LAST) ? '0 : vcount_reg + 1'b1;
        end

        vblank_src_nz = 1'b0;
        if (vsync_reg == '0)
        begin
            vsync_next    = VSYNC_RELOAD;
            vblank_src_nz = (VBLANK_LOAD != '0);
            vblank_next   = VBLANK_LOAD;
        end
        else
        begin
            vsync_next    = vsync_reg - 1'b1;
            vblank_src_nz = (vblank_reg != '0);
            vblank_next   = vblank_reg;
        end

        // Count down vblank and hold the scanline at the top of frame.
        vcount_next = vcount_adv;
        if (vblank_src_nz)
        begin
            vblank_next = vblank_next - 1'b1;
            vcount_next = '0;
        end

        scan_next = avtio_pkg::SCANLINE_W'(vcount_next);
    end

    // Bus decode for this tick's access.
    always_comb
    begin
        nmi_en_next = nmi_en_reg;

        rsp_data_next              = '0;
        rsp_data_next.nmi_level    = nmi_en_reg && (vblank_next != '0);
        rsp_data_next.scanline     = scan_next;

        case (cmd.data.req_type)
            avtio_pkg::REQ_READ:
            begin
                rsp_data_next.io_read_hit = 1'b1;
                case (cmd.data.bus_addr)
                    avtio_pkg::ADDR_SCANLINE:
                        rsp_data_next.io_read_data = scan_next[avtio_pkg::DATA_W-1:0];
                    avtio_pkg::ADDR_IN0:
                        rsp_data_next.io_read_data = cmd.data.port_in0;
                    avtio_pkg::ADDR_IN1:
                        rsp_data_next.io_read_data = cmd.data.port_in1;
                    avtio_pkg::ADDR_IN2:
                        rsp_data_next.io_read_data = cmd.data.port_in2;
                    avtio_pkg::ADDR_DSW0:
                        rsp_data_next.io_read_data = dip0_reg;
                    avtio_pkg::ADDR_DSW1:
                        rsp_data_next.io_read_data = dip1_reg;
                    default:
                    begin
                        // Not a board register: forward to memory.
                        rsp_data_next.io_read_hit = 1'b0;
                        rsp_data_next.mem_read    = 1'b1;
                        rsp_data_next.mem_addr    = cmd.data.bus_addr;
                    end
                endcase
            end
            avtio_pkg::REQ_WRITE:
            begin
                case (cmd.data.bus_addr)
                    avtio_pkg::ADDR_NMI_EN:
                        nmi_en_next = cmd.data.bus_wdata[0];
                    avtio_pkg::ADDR_SCANLINE,
                    avtio_pkg::ADDR_DSW1,
                    avtio_pkg::ADDR_LATCH_2,
                    avtio_pkg::ADDR_LATCH_4,
                    avtio_pkg::ADDR_LATCH_8,
                    avtio_pkg::ADDR_LATCH_A,
                    avtio_pkg::ADDR_LATCH_C:
                    begin
                        // Board latches with no effect here: drop the write.
                    end
                    default:
                    begin
                        rsp_data_next.mem_write = 1'b1;
                        rsp_data_next.mem_addr  = cmd.data.bus_addr;
                        rsp_data_next.mem_wdata = cmd.data.bus_wdata;
                    end
                endcase
            end
            default:
            begin
                // No access (and the unused code): timing only.
            end
        endcase
    end

    // Timing and NMI enable state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg <= '0;
            vcount_reg <= '0;
            vsync_reg  <= '0;
            vblank_reg <= '0;
            nmi_en_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            hcount_reg <= hcount_next;
            vcount_reg <= vcount_next;
            vsync_reg  <= vsync_next;
            vblank_reg <= vblank_next;
            nmi_en_reg <= nmi_en_next;
        end
    end

    // DIP switch banks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip0_reg <= '0;
            dip1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                avtio_pkg::CFG_DIP_SWITCH_0: dip0_reg <= cfg_wdata;
                avtio_pkg::CFG_DIP_SWITCH_1: dip1_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Result valid: set on a new request, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd_take)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // Result payload: load only with a new request.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            rsp_data_reg <= rsp_data_next;
    end

    // At most one of decoded read, forwarded read and forwarded write per result
    assign rsp_targets = {rsp_data_reg.io_read_hit, rsp_data_reg.mem_read,
                          rsp_data_reg.mem_write};

    `AVTIO_ASSERT_ALWAYS(a_hcount_range, clk, (!rst_n || (hcount_reg <= HCOUNT_LAST)))
    `AVTIO_ASSERT(a_vblank_top, clk, rst_n, (vblank_reg != '0) |-> (vcount_reg == '0))
    `AVTIO_ASSERT(a_hcount_moves, clk, rst_n, cmd_take |=> (hcount_reg != $past(hcount_reg)))
    `AVTIO_ASSERT(a_one_target, clk, rst_n, rsp_valid_reg |-> ($countones(rsp_targets) <= 1))
endmodule
